### rtl/nnts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnts_pkg
// shared widths, register map, controller command and status types
// ----------------------------------------------------------------------------
package nnts_pkg;

  localparam int unsigned SideW = 13;
  localparam int unsigned PixW  = 8;
  localparam int unsigned CntW  = 12;
  localparam int unsigned AccW  = 26;
  localparam int unsigned SumW  = AccW + 1;
  localparam int unsigned ProdW = 2 * SideW;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [SideW-1:0] MaxSide = SideW'(4096);

  localparam logic [1:0] RegSrcWidth  = 2'd0;
  localparam logic [1:0] RegSrcHeight = 2'd1;
  localparam logic [1:0] RegMaxDim    = 2'd2;

  localparam logic [SideW-1:0] RstSrcWidth  = SideW'(1280);
  localparam logic [SideW-1:0] RstSrcHeight = SideW'(720);
  localparam logic [SideW-1:0] RstMaxDim    = SideW'(256);

  typedef struct packed {
    logic step;
    logic use_held;
    logic hold_pix;
    logic div_start;
    logic div_sel_h;
    logic latch_w;
    logic latch_h;
    logic restart;
  } nnts_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic div_done;
  } nnts_stat_t;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > MaxSide) begin
      r = MaxSide;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/nnts_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnts_if
// valid/ready channels for source pixels and thumbnail pixels
// ----------------------------------------------------------------------------
interface nnts_pix_if import nnts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            start_of_frame;
  logic [PixW-1:0] red_in;
  logic [PixW-1:0] green_in;
  logic [PixW-1:0] blue_in;

  modport source (output valid, output start_of_frame, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input start_of_frame, input red_in, input green_in,
                input blue_in, output ready);
endinterface

interface nnts_thumb_if import nnts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PixW-1:0]  blue_out;
  logic [PixW-1:0]  green_out;
  logic [PixW-1:0]  red_out;
  logic [SideW-1:0] thumb_width;
  logic [SideW-1:0] thumb_height;
  logic             last_of_frame;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output thumb_width, output thumb_height, output last_of_frame,
                  input ready);
  modport sink (input valid, input blue_out, input green_out, input red_out,
                input thumb_width, input thumb_height, input last_of_frame,
                output ready);
endinterface
`default_nettype wire

### rtl/nnts_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnts_div
// multiply then bit-serial restoring divide, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnts_div import nnts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SideW-1:0] side_i,
  input  wire logic [SideW-1:0] scale_i,
  input  wire logic [SideW-1:0] divisor_i,
  output logic                  done_o,
  output logic [SideW-1:0]      quo_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0]   num_q, num_d;
  logic [SideW-1:0]   rem_q, rem_d;
  logic [SideW-1:0]   div_q, div_d;
  logic [SideW:0]     trial;
  logic               ge;

  assign trial = {rem_q, num_q[ProdW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = ProdW'(side_i) * ProdW'(scale_i);
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[ProdW-2:0], ge};
      rem_d = ge ? SideW'(trial - {1'b0, div_q}) : trial[SideW-1:0];
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q[SideW-1:0];

endmodule
`default_nettype wire

### rtl/nnts_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnts_dp
// position counters, sampling accumulators, size registers, output register
// ----------------------------------------------------------------------------
module nnts_dp import nnts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire nnts_cmd_t        cmd_i,
  output nnts_stat_t            stat_o,
  input  wire logic [SideW-1:0] w_i,
  input  wire logic [SideW-1:0] h_i,
  input  wire logic [SideW-1:0] m_i,
  input  wire logic [PixW-1:0]  red_i,
  input  wire logic [PixW-1:0]  green_i,
  input  wire logic [PixW-1:0]  blue_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output logic [PixW-1:0]       blue_o,
  output logic [PixW-1:0]       green_o,
  output logic [PixW-1:0]       red_o,
  output logic [SideW-1:0]      thumb_width_o,
  output logic [SideW-1:0]      thumb_height_o,
  output logic                  last_o
);

  logic [CntW-1:0]  scol_q, scol_d, srow_q, srow_d;
  logic [SideW-1:0] tcol_q, tcol_d, trow_q, trow_d;
  logic [AccW-1:0]  ctacc_q, ctacc_d, cbacc_q, cbacc_d;
  logic [AccW-1:0]  rtacc_q, rtacc_d, rbacc_q, rbacc_d;
  logic [SideW-1:0] dw_q, dw_d, dh_q, dh_d;
  logic             out_valid_q, out_valid_d;
  logic [PixW-1:0]  hred_q, hgreen_q, hblue_q;
  logic [PixW-1:0]  ored_q, ogreen_q, oblue_q;
  logic [SideW-1:0] odw_q, odh_q;
  logic             olast_q;

  logic [PixW-1:0]  pred, pgreen, pblue;
  logic [SideW-1:0] largest, quo, quo_nz, dim_new;
  logic             fits, div_done, slot_free;
  logic [SumW-1:0]  col_sum, col_lim, row_sum, row_lim;
  logic             col_hit, row_hit, hit, last;

  assign largest = (w_i > h_i) ? w_i : h_i;
  assign fits    = m_i >= largest;

  nnts_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .side_i    (cmd_i.div_sel_h ? h_i : w_i),
    .scale_i   (m_i),
    .divisor_i (largest),
    .done_o    (div_done),
    .quo_o     (quo)
  );

  assign quo_nz  = (quo == '0) ? SideW'(1) : quo;
  assign dim_new = fits ? (cmd_i.latch_h ? h_i : w_i) : quo_nz;

  assign slot_free = !out_valid_q || out_ready_i;
  assign stat_o    = '{slot_free: slot_free, div_done: div_done};

  assign pred   = cmd_i.use_held ? hred_q   : red_i;
  assign pgreen = cmd_i.use_held ? hgreen_q : green_i;
  assign pblue  = cmd_i.use_held ? hblue_q  : blue_i;

  assign col_sum = SumW'(ctacc_q) + SumW'(w_i);
  assign col_lim = SumW'(cbacc_q) + SumW'({dw_q, 1'b0});
  assign row_sum = SumW'(rtacc_q) + SumW'(h_i);
  assign row_lim = SumW'(rbacc_q) + SumW'({dh_q, 1'b0});

  assign col_hit = (tcol_q < dw_q) && (SumW'(cbacc_q) <= col_sum) && (col_sum < col_lim);
  assign row_hit = (trow_q < dh_q) && (SumW'(rbacc_q) <= row_sum) && (row_sum < row_lim);
  assign hit     = col_hit && row_hit;
  assign last    = ((SideW+1)'(tcol_q) + (SideW+1)'(1) == (SideW+1)'(dw_q)) &&
                   ((SideW+1)'(trow_q) + (SideW+1)'(1) == (SideW+1)'(dh_q));

  always_comb begin
    scol_d  = scol_q;
    srow_d  = srow_q;
    tcol_d  = tcol_q;
    trow_d  = trow_q;
    ctacc_d = ctacc_q;
    cbacc_d = cbacc_q;
    rtacc_d = rtacc_q;
    rbacc_d = rbacc_q;
    dw_d    = cmd_i.latch_w ? dim_new : dw_q;
    dh_d    = cmd_i.latch_h ? dim_new : dh_q;
    if (cmd_i.restart) begin
      scol_d  = '0;
      srow_d  = '0;
      tcol_d  = '0;
      trow_d  = '0;
      ctacc_d = '0;
      cbacc_d = '0;
      rtacc_d = '0;
      rbacc_d = '0;
    end else if (cmd_i.step) begin
      if (col_hit) begin
        tcol_d  = tcol_q + SideW'(1);
        ctacc_d = ctacc_q + AccW'({w_i, 1'b0});
      end
      if (SideW'(scol_q) + SideW'(1) >= w_i) begin
        scol_d  = '0;
        cbacc_d = '0;
        tcol_d  = '0;
        ctacc_d = '0;
        if (row_hit) begin
          trow_d  = trow_q + SideW'(1);
          rtacc_d = rtacc_q + AccW'({h_i, 1'b0});
        end
        if (SideW'(srow_q) + SideW'(1) >= h_i) begin
          srow_d  = '0;
          rbacc_d = '0;
          trow_d  = '0;
          rtacc_d = '0;
        end else begin
          srow_d  = srow_q + CntW'(1);
          rbacc_d = rbacc_q + AccW'({dh_q, 1'b0});
        end
      end else begin
        scol_d  = scol_q + CntW'(1);
        cbacc_d = cbacc_q + AccW'({dw_q, 1'b0});
      end
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (cmd_i.step && hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q      <= '0;
      srow_q      <= '0;
      tcol_q      <= '0;
      trow_q      <= '0;
      ctacc_q     <= '0;
      cbacc_q     <= '0;
      rtacc_q     <= '0;
      rbacc_q     <= '0;
      dw_q        <= SideW'(1);
      dh_q        <= SideW'(1);
      out_valid_q <= 1'b0;
    end else begin
      scol_q      <= scol_d;
      srow_q      <= srow_d;
      tcol_q      <= tcol_d;
      trow_q      <= trow_d;
      ctacc_q     <= ctacc_d;
      cbacc_q     <= cbacc_d;
      rtacc_q     <= rtacc_d;
      rbacc_q     <= rbacc_d;
      dw_q        <= dw_d;
      dh_q        <= dh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_pix) begin
      hred_q   <= red_i;
      hgreen_q <= green_i;
      hblue_q  <= blue_i;
    end
    if (cmd_i.step && hit) begin
      ored_q   <= pred;
      ogreen_q <= pgreen;
      oblue_q  <= pblue;
      odw_q    <= dw_q;
      odh_q    <= dh_q;
      olast_q  <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_o         = oblue_q;
  assign green_o        = ogreen_q;
  assign red_o          = ored_q;
  assign thumb_width_o  = odw_q;
  assign thumb_height_o = odh_q;
  assign last_o         = olast_q;

endmodule
`default_nettype wire

### rtl/nnts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nnts_ctrl
// sequences pixel steps and the two size divisions at frame start
// ----------------------------------------------------------------------------
module nnts_ctrl import nnts_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_sof_i,
  output logic            in_ready_o,
  input  wire nnts_stat_t stat_i,
  output nnts_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    StRun  = 4'b0001,
    StDivW = 4'b0010,
    StDivH = 4'b0100,
    StEmit = 4'b1000
  } nnts_state_e;

  nnts_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StRun: begin
        in_ready_o = stat_i.slot_free;
        if (in_valid_i && stat_i.slot_free) begin
          if (in_sof_i) begin
            cmd_o.hold_pix  = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = StDivW;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      StDivW: begin
        if (stat_i.div_done) begin
          cmd_o.latch_w   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel_h = 1'b1;
          state_d         = StDivH;
        end
      end
      StDivH: begin
        cmd_o.div_sel_h = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.latch_h = 1'b1;
          cmd_o.restart = 1'b1;
          state_d       = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.slot_free) begin
          cmd_o.step     = 1'b1;
          cmd_o.use_held = 1'b1;
          state_d        = StRun;
        end
      end
      default: state_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/nearest_neighbour_thumbnail_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_thumbnail_scaler
// nearest-neighbor thumbnail downscale of an rgb raster stream, bgr output
// output: a sampled pixel is registered and shown in the cycle after its step
// throughput: one item per cycle while the output is free; a start_of_frame
//   item waits while the bit-serial divider runs for width, then for height
// reset: registers 1280 x 720 / 256, thumbnail size 1 x 1, counters zero
// ----------------------------------------------------------------------------
module nearest_neighbour_thumbnail_scaler import nnts_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  nnts_pix_if.sink              pix_i,
  nnts_thumb_if.source          thumb_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  logic [SideW-1:0] src_width_q, src_height_q, max_dim_q;
  logic [SideW-1:0] w, h, m;
  logic             wr_en;
  logic [1:0]       reg_idx;
  nnts_cmd_t        cmd;
  nnts_stat_t       stat;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RstSrcWidth;
      src_height_q <= RstSrcHeight;
      max_dim_q    <= RstMaxDim;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSrcWidth:  src_width_q  <= pwdata[SideW-1:0];
        RegSrcHeight: src_height_q <= pwdata[SideW-1:0];
        RegMaxDim:    max_dim_q    <= pwdata[SideW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSrcWidth:  prdata = DataW'(src_width_q);
      RegSrcHeight: prdata = DataW'(src_height_q);
      RegMaxDim:    prdata = DataW'(max_dim_q);
      default:      prdata = '0;
    endcase
  end

  assign w = clamp_side(src_width_q);
  assign h = clamp_side(src_height_q);
  assign m = clamp_side(max_dim_q);

  nnts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_sof_i   (pix_i.start_of_frame),
    .in_ready_o (pix_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nnts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .w_i            (w),
    .h_i            (h),
    .m_i            (m),
    .red_i          (pix_i.red_in),
    .green_i        (pix_i.green_in),
    .blue_i         (pix_i.blue_in),
    .out_ready_i    (thumb_o.ready),
    .out_valid_o    (thumb_o.valid),
    .blue_o         (thumb_o.blue_out),
    .green_o        (thumb_o.green_out),
    .red_o          (thumb_o.red_out),
    .thumb_width_o  (thumb_o.thumb_width),
    .thumb_height_o (thumb_o.thumb_height),
    .last_o         (thumb_o.last_of_frame)
  );

endmodule
`default_nettype wire

### tb/nearest_neighbour_thumbnail_scaler_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_thumbnail_scaler_tb
// streams rgb frames of many sizes through the scaler and checks each bgr
// thumbnail pixel against a cycle-free predictor of the downscale; a short
// table of hand-picked items comes first, then random frames with random
// stalls on both channels, a long receiver hold-off and register changes
// between frames
// ----------------------------------------------------------------------------
module nearest_neighbour_thumbnail_scaler_tb;
  import nnts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdlePct     = 21;
  localparam int unsigned QuietCycles = 100;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned FrameCap    = 48;
  localparam int unsigned RandPix     = 750;
  localparam int unsigned CalmFrom    = 400;
  localparam int unsigned CalmTo      = 560;
  localparam int unsigned DirRows     = 41;

  typedef enum logic {ROW_REG, ROW_PIX} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} check_e;
  typedef enum logic [1:0] {FRAME_CLEAN, FRAME_SHORT, FRAME_NOISE, FRAME_NO_SOF} frame_style_e;

  typedef struct packed {
    logic [PixW-1:0]  blue;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  red;
    logic [SideW-1:0] thumb_w;
    logic [SideW-1:0] thumb_h;
    logic             last_pix;
  } thumb_pix_t;

  typedef struct {
    row_kind_e        kind;
    logic [1:0]       reg_idx;
    logic [SideW-1:0] reg_val;
    logic             sof;
    logic [PixW-1:0]  red;
    logic [PixW-1:0]  green;
    logic [PixW-1:0]  blue;
    check_e           chk;
    thumb_pix_t       want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  nnts_pix_if   pix_if ();
  nnts_thumb_if thumb_if ();

  nearest_neighbour_thumbnail_scaler u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .thumb_o (thumb_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [SideW-1:0] reg_src_w, reg_src_h, reg_max_dim;
  logic [SideW-1:0] src_col, src_row, thb_col, thb_row, thb_w, thb_h;
  logic [AccW-1:0]  col_tgt, col_base, row_tgt, row_base;

  thumb_pix_t  expected_thumb_q[$];
  int unsigned fail_cnt = 0;
  int unsigned pix_sent = 0;
  bit          no_idle = 1'b0;
  bit          stall_burst_req = 1'b0;
  bit          stall_burst_done = 1'b0;
  dir_row_t    dir_tab [DirRows];

  function automatic logic [SideW-1:0] clamp_dim(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > MaxSide) begin
      r = MaxSide;
    end
    return r;
  endfunction

  function automatic logic [SideW-1:0] thumb_side(input logic [SideW-1:0] side, m, big);
    logic [ProdW-1:0] q;
    if (m >= big) begin
      return side;
    end
    q = (ProdW'(side) * ProdW'(m)) / ProdW'(big);
    return (q == '0) ? SideW'(1) : SideW'(q);
  endfunction

  function automatic void clear_position();
    src_col  = '0;
    src_row  = '0;
    thb_col  = '0;
    thb_row  = '0;
    col_tgt  = '0;
    col_base = '0;
    row_tgt  = '0;
    row_base = '0;
  endfunction

  // advances the raster position by one source pixel, returns 1 when it is sampled
  function automatic logic sample_source_pixel(input logic sof,
                                               input logic [PixW-1:0] r, g, b,
                                               output thumb_pix_t px);
    logic [SideW-1:0] w, h, m, big;
    logic [SumW-1:0]  col_reach, row_reach;
    logic             col_hit, row_hit;
    w = clamp_dim(reg_src_w);
    h = clamp_dim(reg_src_h);
    if (sof) begin
      m = clamp_dim(reg_max_dim);
      big = (w > h) ? w : h;
      thb_w = thumb_side(w, m, big);
      thb_h = thumb_side(h, m, big);
      clear_position();
    end
    col_reach = SumW'(col_tgt) + SumW'(w);
    row_reach = SumW'(row_tgt) + SumW'(h);
    col_hit = (thb_col < thb_w) && (SumW'(col_base) <= col_reach) &&
              (col_reach < SumW'(col_base) + SumW'({thb_w, 1'b0}));
    row_hit = (thb_row < thb_h) && (SumW'(row_base) <= row_reach) &&
              (row_reach < SumW'(row_base) + SumW'({thb_h, 1'b0}));
    px.blue     = b;
    px.green    = g;
    px.red      = r;
    px.thumb_w  = thb_w;
    px.thumb_h  = thb_h;
    px.last_pix = (thb_col + SideW'(1) == thb_w) && (thb_row + SideW'(1) == thb_h);
    if (col_hit) begin
      thb_col = thb_col + SideW'(1);
      col_tgt = col_tgt + AccW'({w, 1'b0});
    end
    if (src_col + SideW'(1) >= w) begin
      src_col  = '0;
      col_base = '0;
      thb_col  = '0;
      col_tgt  = '0;
      if (row_hit) begin
        thb_row = thb_row + SideW'(1);
        row_tgt = row_tgt + AccW'({h, 1'b0});
      end
      if (src_row + SideW'(1) >= h) begin
        src_row  = '0;
        row_base = '0;
        thb_row  = '0;
        row_tgt  = '0;
      end else begin
        src_row  = src_row + SideW'(1);
        row_base = row_base + AccW'({thb_h, 1'b0});
      end
    end else begin
      src_col  = src_col + SideW'(1);
      col_base = col_base + AccW'({thb_w, 1'b0});
    end
    return col_hit && row_hit;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [SideW-1:0] val);
    dir_row_t row;
    row = '{kind: ROW_REG, reg_idx: idx, reg_val: val, sof: 1'b0, red: '0, green: '0,
            blue: '0, chk: CHK_NONE, want: '0};
    return row;
  endfunction

  function automatic dir_row_t pix_row(input logic sof, input logic [PixW-1:0] r, g, b,
                                       input check_e chk, input thumb_pix_t want);
    dir_row_t row;
    row = '{kind: ROW_PIX, reg_idx: '0, reg_val: '0, sof: sof, red: r, green: g, blue: b,
            chk: chk, want: want};
    return row;
  endfunction

  function automatic logic [SideW-1:0] extreme_side();
    logic [SideW-1:0] v;
    case ($urandom_range(3))
      0: v = '0;
      1: v = MaxSide;
      2: v = '1;
      default: v = SideW'($urandom);
    endcase
    return v;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(input logic sof, input logic [PixW-1:0] r, g, b,
                            input check_e chk, input thumb_pix_t want);
    thumb_pix_t px;
    logic       hit;
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_if.valid          <= 1'b1;
    pix_if.start_of_frame <= sof;
    pix_if.red_in         <= r;
    pix_if.green_in       <= g;
    pix_if.blue_in        <= b;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    hit = sample_source_pixel(sof, r, g, b, px);
    case (chk)
      CHK_MODEL: if (hit) expected_thumb_q.push_back(px);
      CHK_TYPED: expected_thumb_q.push_back(want);
      default: ;
    endcase
    pix_sent++;
    no_idle = (pix_sent >= CalmFrom) && (pix_sent < CalmTo);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int unsigned n_pix, input frame_style_e style);
    int unsigned len;
    logic        sof;
    len = n_pix;
    if (style == FRAME_SHORT && n_pix > 1) len = $urandom_range(1, n_pix - 1);
    for (int unsigned i = 0; i < len; i++) begin
      if (style == FRAME_NOISE) begin
        sof = ($urandom_range(7) == 0);
      end else begin
        sof = (i == 0) && (style != FRAME_NO_SOF);
      end
      send_pixel(sof, PixW'($urandom), PixW'($urandom), PixW'($urandom), CHK_MODEL, '0);
    end
  endtask

  task automatic wait_quiet();
    pix_if.valid <= 1'b0;
    while (expected_thumb_q.size() != 0) @(negedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [SideW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegSrcWidth:  reg_src_w = val;
      RegSrcHeight: reg_src_h = val;
      RegMaxDim:    reg_max_dim = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [SideW-1:0] w_val, h_val, m_val;
    int unsigned      n_pix, n_frames;
    frame_style_e     style;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    pix_if.valid          <= 1'b0;
    pix_if.start_of_frame <= 1'b0;
    pix_if.red_in         <= '0;
    pix_if.green_in       <= '0;
    pix_if.blue_in        <= '0;
    reg_src_w   = RstSrcWidth;
    reg_src_h   = RstSrcHeight;
    reg_max_dim = RstMaxDim;
    thb_w = SideW'(1);
    thb_h = SideW'(1);
    clear_position();

    dir_tab = '{
      // reset size 1 x 1 samples far into the frame
      pix_row(1'b0, 8'h00, 8'h00, 8'h00, CHK_NONE, '0),
      pix_row(1'b0, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, '0),
      reg_row(RegSrcWidth, 13'd1),
      reg_row(RegSrcHeight, 13'd1),
      reg_row(RegMaxDim, 13'd1),
      pix_row(1'b1, 8'hFF, 8'h00, 8'hAA, CHK_TYPED,
              '{8'hAA, 8'h00, 8'hFF, 13'd1, 13'd1, 1'b1}),
      // next frame without start_of_frame
      pix_row(1'b0, 8'h12, 8'h34, 8'h56, CHK_TYPED,
              '{8'h56, 8'h34, 8'h12, 13'd1, 13'd1, 1'b1}),
      // zero registers count as one
      reg_row(RegSrcWidth, 13'd0),
      reg_row(RegSrcHeight, 13'd0),
      reg_row(RegMaxDim, 13'd0),
      pix_row(1'b1, 8'h00, 8'hFF, 8'h00, CHK_TYPED,
              '{8'h00, 8'hFF, 8'h00, 13'd1, 13'd1, 1'b1}),
      // oversized width, height scales below one
      reg_row(RegSrcWidth, 13'h1FFF),
      reg_row(RegSrcHeight, 13'd2),
      reg_row(RegMaxDim, 13'd2),
      pix_row(1'b1, 8'h01, 8'h02, 8'h03, CHK_MODEL, '0),
      pix_row(1'b0, 8'h80, 8'h40, 8'h20, CHK_MODEL, '0),
      // no scaling, early start_of_frame drops the partial frame
      reg_row(RegSrcWidth, 13'd3),
      reg_row(RegSrcHeight, 13'd2),
      reg_row(RegMaxDim, 13'h1FFF),
      pix_row(1'b1, 8'h10, 8'h11, 8'h12, CHK_MODEL, '0),
      pix_row(1'b0, 8'h20, 8'h21, 8'h22, CHK_MODEL, '0),
      pix_row(1'b0, 8'h30, 8'h31, 8'h32, CHK_MODEL, '0),
      pix_row(1'b0, 8'h40, 8'h41, 8'h42, CHK_MODEL, '0),
      pix_row(1'b0, 8'h50, 8'h51, 8'h52, CHK_MODEL, '0),
      pix_row(1'b0, 8'h60, 8'h61, 8'h62, CHK_MODEL, '0),
      pix_row(1'b0, 8'h70, 8'h71, 8'h72, CHK_MODEL, '0),
      pix_row(1'b1, 8'h7F, 8'hFE, 8'hEF, CHK_MODEL, '0),
      // 8 x 1 scaled to 2 x 1, width changed mid-frame
      reg_row(RegSrcWidth, 13'd8),
      reg_row(RegSrcHeight, 13'd1),
      reg_row(RegMaxDim, 13'd2),
      pix_row(1'b1, 8'hA0, 8'hA1, 8'hA2, CHK_MODEL, '0),
      pix_row(1'b0, 8'hB0, 8'hB1, 8'hB2, CHK_MODEL, '0),
      pix_row(1'b0, 8'hC0, 8'hC1, 8'hC2, CHK_MODEL, '0),
      pix_row(1'b0, 8'hD0, 8'hD1, 8'hD2, CHK_MODEL, '0),
      pix_row(1'b0, 8'hE0, 8'hE1, 8'hE2, CHK_MODEL, '0),
      pix_row(1'b0, 8'hF0, 8'hF1, 8'hF2, CHK_MODEL, '0),
      reg_row(RegSrcWidth, 13'd4),
      pix_row(1'b0, 8'h05, 8'h06, 8'h07, CHK_MODEL, '0),
      pix_row(1'b0, 8'h15, 8'h16, 8'h17, CHK_MODEL, '0),
      pix_row(1'b0, 8'h25, 8'h26, 8'h27, CHK_MODEL, '0),
      pix_row(1'b0, 8'h35, 8'h36, 8'h37, CHK_MODEL, '0)
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < DirRows; i++) begin
      if (dir_tab[i].kind == ROW_REG) begin
        wait_quiet();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_pixel(dir_tab[i].sof, dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue,
                   dir_tab[i].chk, dir_tab[i].want);
      end
    end

    // every source pixel sampled while the receiver holds off
    wait_quiet();
    write_reg(RegSrcWidth, 13'd4);
    write_reg(RegSrcHeight, 13'd4);
    write_reg(RegMaxDim, 13'd16);
    stall_burst_req = 1'b1;
    repeat (3) send_frame(16, FRAME_CLEAN);

    while (pix_sent < RandPix) begin
      wait_quiet();
      case ($urandom_range(9))
        7: begin
          w_val = extreme_side();
          h_val = SideW'($urandom_range(1, 3));
        end
        8: begin
          w_val = SideW'($urandom_range(1, 3));
          h_val = extreme_side();
        end
        default: begin
          w_val = SideW'($urandom_range(1, 10));
          h_val = SideW'($urandom_range(1, 8));
        end
      endcase
      m_val = ($urandom_range(4) == 0) ? extreme_side() : SideW'($urandom_range(1, 12));
      write_reg(RegSrcWidth, w_val);
      write_reg(RegSrcHeight, h_val);
      write_reg(RegMaxDim, m_val);
      n_pix = int'(clamp_dim(w_val)) * int'(clamp_dim(h_val));
      if (n_pix > FrameCap) n_pix = FrameCap;
      n_frames = $urandom_range(1, 3);
      repeat (n_frames) begin
        case ($urandom_range(9))
          0: style = FRAME_SHORT;
          1: style = FRAME_NOISE;
          2: style = FRAME_NO_SOF;
          default: style = FRAME_CLEAN;
        endcase
        send_frame(n_pix, style);
      end
    end

    wait_quiet();
    if (fail_cnt == 0) begin
      $display("nearest_neighbour_thumbnail_scaler_tb OK");
    end else begin
      $display("nearest_neighbour_thumbnail_scaler_tb NOT OK");
    end
    $finish;
  end

  initial begin : thumb_sink
    int unsigned hold_cnt;
    thumb_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_burst_req && !stall_burst_done) begin
        thumb_if.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HoldCycles; hold_cnt++) @(negedge clk_i);
        stall_burst_done = 1'b1;
      end
      thumb_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin : check_thumb
    thumb_pix_t got, want;
    if (rst_ni && thumb_if.valid && thumb_if.ready) begin
      got.blue     = thumb_if.blue_out;
      got.green    = thumb_if.green_out;
      got.red      = thumb_if.red_out;
      got.thumb_w  = thumb_if.thumb_width;
      got.thumb_h  = thumb_if.thumb_height;
      got.last_pix = thumb_if.last_of_frame;
      if (expected_thumb_q.size() == 0) begin
        if (fail_cnt < 10) begin
          $display("%0t: unexpected thumb item bgr %h %h %h size %0d x %0d last %b",
                   $realtime, got.blue, got.green, got.red, got.thumb_w, got.thumb_h,
                   got.last_pix);
        end
        fail_cnt++;
      end else begin
        want = expected_thumb_q.pop_front();
        if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
            got.thumb_w !== want.thumb_w || got.thumb_h !== want.thumb_h ||
            got.last_pix !== want.last_pix) begin
          if (fail_cnt < 10) begin
            $display("%0t: thumb item mismatch exp bgr %h %h %h size %0d x %0d last %b",
                     $realtime, want.blue, want.green, want.red, want.thumb_w,
                     want.thumb_h, want.last_pix);
            $display("%0t:                     got bgr %h %h %h size %0d x %0d last %b",
                     $realtime, got.blue, got.green, got.red, got.thumb_w, got.thumb_h,
                     got.last_pix);
          end
          fail_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("nearest_neighbour_thumbnail_scaler_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
